### rtl/core/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg: shared definitions for the keyboard scancode decoder
// Scancode constants, action codes, keymap ROMs and the result record.
// ----------------------------------------------------------------------------
package ksd_pkg;

  // Configuration constants
  localparam int unsigned NUM_VIEWS    = 3;
  localparam int unsigned VISIBLE_ROWS = 25;
  localparam int unsigned MAX_LINES    = 4096;

  // Field widths
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned LINE_W  = 12;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned VIEW_W  = 2;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned KEYMAP_SIZE = 58;
  localparam int unsigned KEY_IDX_W   = 6;

  // Offset ceiling: min(MAX_LINES - 1, 4095)
  localparam int unsigned OFFSET_CAP_INT = (MAX_LINES - 1 < 4095) ? MAX_LINES - 1 : 4095;
  localparam logic [LINE_W-1:0] OFFSET_CAP = LINE_W'(OFFSET_CAP_INT);

  // Scancodes
  localparam logic [CODE_W-1:0] CODE_PREFIX    = 8'hE0;
  localparam logic [CODE_W-1:0] CODE_UP        = 8'h48;
  localparam logic [CODE_W-1:0] CODE_DOWN      = 8'h50;
  localparam logic [CODE_W-1:0] CODE_BKSP      = 8'h0E;
  localparam logic [CODE_W-1:0] CODE_RELEASE   = 8'h80;
  localparam logic [CODE_W-1:0] CODE_LSHIFT    = 8'h2A;
  localparam logic [CODE_W-1:0] CODE_RSHIFT    = 8'h36;
  localparam logic [CODE_W-1:0] CODE_LSHIFT_UP = 8'hAA;
  localparam logic [CODE_W-1:0] CODE_RSHIFT_UP = 8'hB6;
  localparam logic [CODE_W-1:0] CODE_CTRL      = 8'h1D;
  localparam logic [CODE_W-1:0] CODE_CTRL_UP   = 8'h9D;

  // Digit range that selects a view under ctrl
  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;
  localparam logic [CHAR_W:0]   VIEW_CHAR_END = (CHAR_W+1)'(32'h31 + NUM_VIEWS);

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_PRINT  = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SWITCH = 3'd3,
    ACT_SCROLL = 3'd4
  } ksd_action_t;

  // One result item
  typedef struct packed {
    ksd_action_t         action;
    logic [CHAR_W-1:0]   char_code;
    logic [VIEW_W-1:0]   view_index;
    logic [LINE_W-1:0]   scroll_amount;
  } ksd_result_t;

  // Unshifted keymap
  localparam logic [CHAR_W-1:0] KEYMAP_LOWER [KEYMAP_SIZE] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
    7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79,
    7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A,
    7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00,
    7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Shifted keymap
  localparam logic [CHAR_W-1:0] KEYMAP_UPPER [KEYMAP_SIZE] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
    7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59,
    7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A,
    7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00,
    7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Keymap lookup; codes past the table give zero
  function automatic logic [CHAR_W-1:0] translate(input logic [CODE_W-1:0] code,
                                                  input logic shifted);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (code < CODE_W'(KEYMAP_SIZE)) begin
      ch = shifted ? KEYMAP_UPPER[code[KEY_IDX_W-1:0]]
                   : KEYMAP_LOWER[code[KEY_IDX_W-1:0]];
    end
    return ch;
  endfunction

endpackage

### rtl/core/ksd_decode.sv
// ----------------------------------------------------------------------------
// ksd_decode: modifier/prefix tracking and per-item decode
// Holds keyboard and view state, decodes one scancode combinationally and
// commits the state update when the item advances.
// ----------------------------------------------------------------------------
module ksd_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [ksd_pkg::CODE_W-1:0] scancode,
  input  logic [ksd_pkg::LINE_W-1:0] line_count,
  output ksd_pkg::ksd_result_t       result
);
  import ksd_pkg::*;

  // State
  logic              shift_held, shift_held_next;
  logic              ctrl_held, ctrl_held_next;
  logic              prefix_pending, prefix_pending_next;
  logic [VIEW_W-1:0] current_view, current_view_next;
  logic [LINE_W-1:0] view_offsets [NUM_VIEWS];

  logic [VIEW_W-1:0] cur_v;
  logic [LINE_W-1:0] cur_off, off_next;
  logic              off_write;
  logic [CHAR_W-1:0] key_char;
  logic              is_press;
  logic              can_scroll_up;
  ksd_action_t       action;
  logic [CHAR_W-1:0] ch;

  // Active view and its offset
  always_comb begin
    cur_v   = (current_view < VIEW_W'(NUM_VIEWS)) ? current_view : '0;
    cur_off = '0;
    for (int i = 0; i < NUM_VIEWS; i++) begin
      if (cur_v == VIEW_W'(i)) cur_off = view_offsets[i];
    end
  end

  assign key_char = translate(scancode, shift_held);
  assign is_press = (scancode & CODE_RELEASE) == '0;

  // offset <= line_count - VISIBLE_ROWS (signed) is offset + rows <= line_count
  assign can_scroll_up = (({1'b0, cur_off} + (LINE_W+1)'(VISIBLE_ROWS)) <= {1'b0, line_count})
                         && (cur_off < OFFSET_CAP);

  // Decode priority chain
  always_comb begin
    shift_held_next     = shift_held;
    ctrl_held_next      = ctrl_held;
    prefix_pending_next = prefix_pending;
    current_view_next   = current_view;
    off_next            = cur_off;
    off_write           = 1'b0;
    action              = ACT_NONE;
    ch                  = '0;
    if (prefix_pending) begin
      prefix_pending_next = 1'b0;
      if (scancode == CODE_UP) begin
        if (can_scroll_up) begin
          off_next  = cur_off + LINE_W'(1);
          off_write = 1'b1;
          action    = ACT_SCROLL;
        end
      end else if (scancode == CODE_DOWN) begin
        if (cur_off != '0) begin
          off_next  = cur_off - LINE_W'(1);
          off_write = 1'b1;
          action    = ACT_SCROLL;
        end
      end
    end else if (scancode == CODE_PREFIX) begin
      prefix_pending_next = 1'b1;
    end else if (scancode == CODE_LSHIFT || scancode == CODE_RSHIFT) begin
      shift_held_next = 1'b1;
    end else if (scancode == CODE_LSHIFT_UP || scancode == CODE_RSHIFT_UP) begin
      shift_held_next = 1'b0;
    end else if (scancode == CODE_CTRL) begin
      ctrl_held_next = 1'b1;
    end else if (scancode == CODE_CTRL_UP) begin
      ctrl_held_next = 1'b0;
    end else if (ctrl_held) begin
      // ctrl + digit selects a view
      if (is_press && key_char >= CHAR_ONE && {1'b0, key_char} < VIEW_CHAR_END) begin
        current_view_next = VIEW_W'(key_char - CHAR_ONE);
        action            = ACT_SWITCH;
      end
    end else if (scancode == CODE_BKSP) begin
      action = ACT_DELETE;
    end else if (is_press) begin
      ch     = key_char;
      action = ACT_PRINT;
    end
  end

  // Result: view and offset after this item
  always_comb begin
    result.action     = action;
    result.char_code  = ch;
    result.view_index = cur_v;
    result.scroll_amount = off_next;
    if (action == ACT_SWITCH) begin
      result.view_index    = current_view_next;
      result.scroll_amount = '0;
      for (int i = 0; i < NUM_VIEWS; i++) begin
        if (current_view_next == VIEW_W'(i)) result.scroll_amount = view_offsets[i];
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      ctrl_held      <= 1'b0;
      prefix_pending <= 1'b0;
      current_view   <= '0;
      for (int i = 0; i < NUM_VIEWS; i++) view_offsets[i] <= '0;
    end else if (en) begin
      shift_held     <= shift_held_next;
      ctrl_held      <= ctrl_held_next;
      prefix_pending <= prefix_pending_next;
      current_view   <= current_view_next;
      for (int i = 0; i < NUM_VIEWS; i++) begin
        if (off_write && cur_v == VIEW_W'(i)) view_offsets[i] <= off_next;
      end
    end
  end

endmodule

### rtl/core/keyboard_scancode_decoder.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder: set-1 scancode to action/character decoder
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   input   | in        | in_valid/in_stall   | scancode, line_count
//   output  | out       | out_valid/out_stall | action, char_code, view_index,
//           |           |                     | scroll_amount
//
// One item per cycle sustained while out_stall stays low. The input register
// captures a transfer, the decode runs on it combinationally and the result
// register is loaded when the item advances, which raises out_valid.
// Reset clears shift, ctrl, prefix, active view and all scroll offsets.
// A stalled result holds the decode stage; in_stall rises only while the
// input register is occupied and a valid result is stalled.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ksd_pkg::CODE_W-1:0] scancode,
  input  logic [ksd_pkg::LINE_W-1:0] line_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ksd_pkg::ACT_W-1:0]  action,
  output logic [ksd_pkg::CHAR_W-1:0] char_code,
  output logic [ksd_pkg::VIEW_W-1:0] view_index,
  output logic [ksd_pkg::LINE_W-1:0] scroll_amount
);
  import ksd_pkg::*;

  logic              s1_valid;
  logic [CODE_W-1:0] s1_scancode;
  logic [LINE_W-1:0] s1_line_count;
  logic              advance;
  logic              in_xfer;
  ksd_result_t       dec_result;
  ksd_result_t       out_result;

  // Stage 1 moves on when the result register is free or being drained
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_scancode   <= scancode;
      s1_line_count <= line_count;
    end
  end

  // Decode and state update
  ksd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .scancode   (s1_scancode),
    .line_count (s1_line_count),
    .result     (dec_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_result <= dec_result;
  end

  assign action        = out_result.action;
  assign char_code     = out_result.char_code;
  assign view_index    = out_result.view_index;
  assign scroll_amount = out_result.scroll_amount;

endmodule
